// ===== hdl/scpr_pkg.sv =====
// ----------------------------------------------------------------------------
// scpr_pkg
// Shared types and codes for the second-chance page replacement block.
// ----------------------------------------------------------------------------
package scpr_pkg;

    // field widths of the request and response words
    localparam int CMD_W    = 2;
    localparam int PAGE_W   = 20;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;
    localparam int OCC_W    = 5;

    // default ring size
    localparam int SLOTS_DEFAULT = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVICT  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_TOUCH  = 2'd3;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // request word
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PAGE_W-1:0] page_number;
    } req_t;

    // response word
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot_index;
        logic [PAGE_W-1:0]   victim_page;
        logic [OCC_W-1:0]    occupancy;
    } rsp_t;

endpackage

// ===== hdl/second_chance_page_replacement.sv =====
// ----------------------------------------------------------------------------
// second_chance_page_replacement
// Second-chance FIFO (clock) replacement over a ring of resident page slots.
// ----------------------------------------------------------------------------
// insert, evict, remove and touch walk the ring with one shared scan pointer
//   that visits one slot per cycle through the single page memory read port
// throughput: one word at a time; a new word is taken once the previous
//   response has been handed to the output register
// reset: valid and referenced bits, head, tail and count clear at once
// ----------------------------------------------------------------------------
module second_chance_page_replacement
#(
    parameter int SLOTS = scpr_pkg::SLOTS_DEFAULT
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  scpr_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output scpr_pkg::rsp_t rsp
);
    import scpr_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [PW-1:0] LAST_POS = PW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SLOTS);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS    = 3'd1;
    localparam logic [2:0] S_EVI    = 3'd2;
    localparam logic [2:0] S_EVI_RD = 3'd3;
    localparam logic [2:0] S_FIND   = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;

    logic [2:0]        state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [PAGE_W-1:0] page_reg, page_next;
    logic [PW-1:0]     pos_reg, pos_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [PW-1:0]     tail_reg, tail_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;
    logic [SLOTS-1:0]  refd_reg, refd_next;
    logic              cmp_live_reg;
    logic [PW-1:0]     cmp_pos_reg;
    rsp_t              res_reg, res_next;
    rsp_t              rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // page store, one write and one registered read port
    logic [PAGE_W-1:0] page_mem [SLOTS];
    logic [PAGE_W-1:0] rd_data_reg;
    logic              mem_we;

    logic [PW-1:0] pos_inc;
    logic          find_hit;
    logic          can_out;

    assign pos_inc  = (pos_reg == LAST_POS) ? '0 : pos_reg + 1'b1;
    assign find_hit = cmp_live_reg && valid_reg[cmp_pos_reg] && (rd_data_reg == page_reg);
    assign can_out  = !rsp_valid_reg || !rsp_stall;

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // page memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            page_mem[pos_reg] <= page_reg;
        end
        rd_data_reg <= page_mem[pos_reg];
    end

    // sequencer and ring update
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        page_next      = page_reg;
        pos_next       = pos_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        valid_next     = valid_reg;
        refd_next      = refd_reg;
        res_next       = res_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        mem_we         = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd_next  = req.command;
                    page_next = req.page_number;
                    res_next  = '0;
                    case (req.command)
                        CMD_INSERT:
                        begin
                            pos_next   = tail_reg;
                            state_next = S_INS;
                        end
                        CMD_EVICT:
                        begin
                            pos_next   = head_reg;
                            state_next = S_EVI;
                        end
                        default:
                        begin
                            pos_next   = '0;
                            state_next = S_FIND;
                        end
                    endcase
                end
            end

            // look for the first free slot from the tail
            S_INS:
            begin
                if (count_reg >= FULL_CNT)
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_DONE;
                end
                else if (!valid_reg[pos_reg])
                begin
                    mem_we              = 1'b1;
                    valid_next[pos_reg] = 1'b1;
                    refd_next[pos_reg]  = 1'b0;
                    count_next          = count_reg + 1'b1;
                    tail_next           = pos_inc;
                    res_next.slot_index = SLOT_W'(pos_reg);
                    state_next          = S_DONE;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            // clock hand: clear referenced bits until an unreferenced page
            S_EVI:
            begin
                if (count_reg == '0)
                begin
                    res_next.status = ST_EMPTY;
                    state_next      = S_DONE;
                end
                else if (valid_reg[pos_reg] && refd_reg[pos_reg])
                begin
                    refd_next[pos_reg] = 1'b0;
                    pos_next           = pos_inc;
                end
                else if (valid_reg[pos_reg])
                begin
                    state_next = S_EVI_RD;
                end
                else
                begin
                    pos_next = pos_inc;
                end
            end

            // victim page arrives from the memory
            S_EVI_RD:
            begin
                valid_next[pos_reg]  = 1'b0;
                count_next           = count_reg - 1'b1;
                head_next            = pos_inc;
                res_next.slot_index  = SLOT_W'(pos_reg);
                res_next.victim_page = rd_data_reg;
                state_next           = S_DONE;
            end

            // search by page number, lowest slot first
            S_FIND:
            begin
                if (find_hit)
                begin
                    res_next.slot_index = SLOT_W'(cmp_pos_reg);
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        valid_next[cmp_pos_reg] = 1'b0;
                        refd_next[cmp_pos_reg]  = 1'b0;
                        count_next              = count_reg - 1'b1;
                        if (cmp_pos_reg == head_reg)
                        begin
                            head_next = (head_reg == LAST_POS) ? '0 : head_reg + 1'b1;
                        end
                        if (cmp_pos_reg == tail_reg)
                        begin
                            tail_next = (tail_reg == '0) ? LAST_POS : tail_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        refd_next[cmp_pos_reg] = 1'b1;
                    end
                    state_next = S_DONE;
                end
                else if (cmp_live_reg && (cmp_pos_reg == LAST_POS))
                begin
                    res_next.status = ST_NOTFOUND;
                    state_next      = S_DONE;
                end
                else if (pos_reg != LAST_POS)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end

            // hand the response to the output register
            S_DONE:
            begin
                if (can_out)
                begin
                    rsp_next           = res_reg;
                    rsp_next.occupancy = OCC_W'(count_reg);
                    rsp_valid_next     = 1'b1;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            valid_reg     <= '0;
            refd_reg      <= '0;
            cmp_live_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            valid_reg     <= valid_next;
            refd_reg      <= refd_next;
            cmp_live_reg  <= (state_reg == S_FIND);
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        page_reg    <= page_next;
        pos_reg     <= pos_next;
        cmp_pos_reg <= pos_reg;
        res_reg     <= res_next;
        rsp_reg     <= rsp_next;
    end

    // occupancy never exceeds the ring size
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FULL_CNT)
        else $error("occupancy above ring size");

    // count tracks the valid bits
    assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(count_reg))
        else $error("occupancy out of step with valid bits");

    // an accepted word starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg != S_IDLE)
        else $error("accepted word did not start a scan");

    // a referenced slot is always a valid slot
    assert property (@(posedge clk) disable iff (!rst_n)
        (refd_reg & ~valid_reg) == '0)
        else $error("referenced bit on a free slot");

endmodule
